FILE: src/cld_pkg.sv
// package for the canvas line and square drawer: constants, types and direction tables
`default_nettype none

package cld_pkg;

    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 64;

    localparam int FUNC_W  = 2;
    localparam int COORD_W = 10;
    localparam int ANGLE_W = 10;
    localparam int SHADE_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_LINE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SQUARE = 2'd1;

    localparam logic [SHADE_W-1:0] SHADE_BLACK = 3'd0;
    localparam logic [SHADE_W-1:0] SHADE_WHITE = 3'd4;

    localparam int ANG_FULL = 360;
    localparam int ANG_STEP = 45;
    localparam int DIR_CNT  = 8;

    typedef struct packed {
        logic                 dir_ok;   // multiple of 45, nonzero length, draw command
        logic                 square;   // fill a block rather than a run
        logic [COORD_W-1:0]   n;        // pixels per side, 0..512
        logic signed [1:0]    dr;
        logic signed [1:0]    dc;
    } t_plan;

    function automatic logic signed [1:0] step_row(input logic [2:0] k);
        logic signed [1:0] s;
        case (k)
            3'd0, 3'd1, 3'd7: s = -2'sd1;
            3'd3, 3'd4, 3'd5: s = 2'sd1;
            default:          s = 2'sd0;
        endcase
        return s;
    endfunction

    function automatic logic signed [1:0] step_col(input logic [2:0] k);
        logic signed [1:0] s;
        case (k)
            3'd1, 3'd2, 3'd3: s = 2'sd1;
            3'd5, 3'd6, 3'd7: s = -2'sd1;
            default:          s = 2'sd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/cld_if.sv
// valid/ready channel interfaces for commands and results
`default_nettype none

interface cld_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [cld_pkg::FUNC_W-1:0]         func;
    logic signed [cld_pkg::COORD_W-1:0] origin_row;
    logic signed [cld_pkg::COORD_W-1:0] origin_col;
    logic signed [cld_pkg::COORD_W-1:0] run_length;
    logic [cld_pkg::ANGLE_W-1:0]        angle_deg;
    logic [cld_pkg::SHADE_W-1:0]        paint_shade;

    modport source (
        output valid, func, origin_row, origin_col, run_length, angle_deg, paint_shade,
        input  ready
    );
    modport sink (
        input  valid, func, origin_row, origin_col, run_length, angle_deg, paint_shade,
        output ready
    );
endinterface

interface cld_res_if;
    logic                        valid;
    logic                        ready;
    logic [cld_pkg::SHADE_W-1:0] start_shade;
    logic                        drew_pixels;

    modport source (output valid, start_shade, drew_pixels, input ready);
    modport sink   (input valid, start_shade, drew_pixels, output ready);
endinterface

`default_nettype wire

FILE: src/cld_plan.sv
// command decode: angle reduction, direction selection and length magnitude
`default_nettype none

module cld_plan (
    input  wire logic [cld_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [cld_pkg::COORD_W-1:0] i_run_length,
    input  wire logic [cld_pkg::ANGLE_W-1:0] i_angle_deg,
    output cld_pkg::t_plan                   o_plan
);

    logic [8:0]                   ang_red;
    logic                         ang_hit;
    logic [2:0]                   k_raw;
    logic [2:0]                   k_dir;
    logic                         neg;
    logic [cld_pkg::COORD_W-1:0]  mag;
    logic                         is_draw;

    // angle below 1024 needs at most two subtractions of a full turn
    always_comb begin
        if (i_angle_deg >= 10'(2 * cld_pkg::ANG_FULL)) begin
            ang_red = 9'(i_angle_deg - 10'(2 * cld_pkg::ANG_FULL));
        end else if (i_angle_deg >= 10'(cld_pkg::ANG_FULL)) begin
            ang_red = 9'(i_angle_deg - 10'(cld_pkg::ANG_FULL));
        end else begin
            ang_red = i_angle_deg[8:0];
        end
    end

    always_comb begin
        ang_hit = 1'b0;
        k_raw   = 3'd0;
        for (int m = 0; m < cld_pkg::DIR_CNT; m++) begin
            if (ang_red == 9'(m * cld_pkg::ANG_STEP)) begin
                ang_hit = 1'b1;
                k_raw   = 3'(m);
            end
        end
    end

    assign neg     = i_run_length[cld_pkg::COORD_W-1];
    // magnitude of the most negative length still fits as unsigned
    assign mag     = neg ? (~i_run_length + 10'd1) : i_run_length;
    assign k_dir   = neg ? (k_raw + 3'd4) : k_raw;
    assign is_draw = (i_func == cld_pkg::FUNC_LINE) || (i_func == cld_pkg::FUNC_SQUARE);

    always_comb begin
        o_plan.dir_ok = ang_hit && is_draw && (mag != '0);
        o_plan.square = (i_func == cld_pkg::FUNC_SQUARE) && k_dir[0];
        o_plan.n      = mag;
        o_plan.dr     = cld_pkg::step_row(k_dir);
        o_plan.dc     = cld_pkg::step_col(k_dir);
    end

endmodule

`default_nettype wire

FILE: src/canvas_line_square_drawer_unit.sv
// canvas line and square drawer: top level with pixel memory and draw sequencer
// sequence: accept, decode, plan, then draw if start and far end are on the canvas
//   (one pixel written per cycle: n for a run, n*n for a diagonal square), read and done;
//   a zero-length line goes from plan straight to done; a new command is taken only in idle
// reset: synchronous active low; a clearing pass then writes white to all ROWS*COLS
//   pixels, one a cycle (2048 pixels by default), with i_cmd.ready low
`default_nettype none

module canvas_line_square_drawer_unit #(
    parameter int ROWS = cld_pkg::ROWS_DEF,
    parameter int COLS = cld_pkg::COLS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cld_cmd_if.sink   i_cmd,
    cld_res_if.source o_res
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int XW    = cld_pkg::COORD_W + 2;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_PLAN   = 3'd3;
    localparam logic [2:0] S_DRAW   = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [cld_pkg::SHADE_W-1:0] mem [DEPTH];

    logic [2:0]                  r_state, n_state;
    logic [AW-1:0]               r_clr;
    logic [cld_pkg::FUNC_W-1:0]  r_func;
    logic [cld_pkg::COORD_W-1:0] r_sr, r_sc, r_len;
    logic [cld_pkg::ANGLE_W-1:0] r_ang;
    logic [cld_pkg::SHADE_W-1:0] r_shade;
    cld_pkg::t_plan              r_plan;
    cld_pkg::t_plan              plan;
    logic [RW-1:0]               r_row, n_row;
    logic [CW-1:0]               r_col, n_col;
    logic [cld_pkg::COORD_W-1:0] r_i, n_i, r_j, n_j;
    logic [AW-1:0]               r_raddr, n_raddr;
    logic [cld_pkg::SHADE_W-1:0] r_rdata;
    logic                        r_zero, n_zero;
    logic                        r_drew, n_drew;
    logic                        r_ovalid;
    logic [cld_pkg::SHADE_W-1:0] r_oshade;
    logic                        r_odrew;

    logic                        accept;
    logic                        out_load;
    logic                        sr_on, sc_on, far_on;
    logic [cld_pkg::COORD_W-1:0] nm1;
    logic [XW-1:0]               fr, fc;
    logic [AW-1:0]               start_addr, pix_addr;
    logic                        last_j, last_i;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [cld_pkg::SHADE_W-1:0] wdata;

    cld_plan u_plan (
        .i_func       (r_func),
        .i_run_length (r_len),
        .i_angle_deg  (r_ang),
        .o_plan       (plan)
    );

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || o_res.ready);

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ovalid;
    assign o_res.start_shade = r_oshade;
    assign o_res.drew_pixels = r_odrew;

    // start and far-end bounds
    assign sr_on = !r_sr[cld_pkg::COORD_W-1] && (r_sr < 10'(ROWS));
    assign sc_on = !r_sc[cld_pkg::COORD_W-1] && (r_sc < 10'(COLS));
    assign nm1   = r_plan.n - 10'd1;

    always_comb begin
        fr = {{2{r_sr[cld_pkg::COORD_W-1]}}, r_sr};
        fc = {{2{r_sc[cld_pkg::COORD_W-1]}}, r_sc};
        if (r_plan.dr == 2'sd1) begin
            fr = fr + {2'b00, nm1};
        end else if (r_plan.dr == -2'sd1) begin
            fr = fr - {2'b00, nm1};
        end
        if (r_plan.dc == 2'sd1) begin
            fc = fc + {2'b00, nm1};
        end else if (r_plan.dc == -2'sd1) begin
            fc = fc - {2'b00, nm1};
        end
    end

    assign far_on = !fr[XW-1] && (fr < XW'(ROWS)) && !fc[XW-1] && (fc < XW'(COLS));

    assign start_addr = AW'(r_sr[RW-1:0]) * AW'(COLS) + AW'(r_sc[CW-1:0]);
    assign pix_addr   = AW'(r_row) * AW'(COLS) + AW'(r_col);

    assign last_j = (r_j == nm1);
    assign last_i = (r_i == nm1);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_i     = r_i;
        n_j     = r_j;
        n_raddr = r_raddr;
        n_zero  = r_zero;
        n_drew  = r_drew;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_PLAN;
            end
            S_PLAN: begin
                n_zero = 1'b0;
                n_drew = 1'b0;
                n_row  = r_sr[RW-1:0];
                n_col  = r_sc[CW-1:0];
                n_i    = '0;
                n_j    = '0;
                if ((r_func == cld_pkg::FUNC_LINE) && (r_len == '0)) begin
                    n_zero  = 1'b1;
                    n_state = S_DONE;
                end else if (!(sr_on && sc_on)) begin
                    n_raddr = '0;
                    n_state = S_READ;
                end else begin
                    n_raddr = start_addr;
                    if (r_plan.dir_ok && far_on) begin
                        n_drew  = 1'b1;
                        n_state = S_DRAW;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_DRAW: begin
                if (r_plan.square && !last_j) begin
                    // next column of the same row
                    n_j = r_j + 10'd1;
                    if (r_plan.dc == 2'sd1) begin
                        n_col = r_col + CW'(1);
                    end else if (r_plan.dc == -2'sd1) begin
                        n_col = r_col - CW'(1);
                    end
                end else begin
                    n_i = r_i + 10'd1;
                    n_j = '0;
                    if (r_plan.dr == 2'sd1) begin
                        n_row = r_row + RW'(1);
                    end else if (r_plan.dr == -2'sd1) begin
                        n_row = r_row - RW'(1);
                    end
                    if (r_plan.square) begin
                        n_col = r_sc[CW-1:0];
                    end else if (r_plan.dc == 2'sd1) begin
                        n_col = r_col + CW'(1);
                    end else if (r_plan.dc == -2'sd1) begin
                        n_col = r_col - CW'(1);
                    end
                    if (last_i) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_cmd.func;
            r_sr    <= i_cmd.origin_row;
            r_sc    <= i_cmd.origin_col;
            r_len   <= i_cmd.run_length;
            r_ang   <= i_cmd.angle_deg;
            r_shade <= (i_cmd.paint_shade > cld_pkg::SHADE_WHITE) ?
                       cld_pkg::SHADE_WHITE : i_cmd.paint_shade;
        end
        if (r_state == S_DECODE) begin
            r_plan <= plan;
        end
        r_row   <= n_row;
        r_col   <= n_col;
        r_i     <= n_i;
        r_j     <= n_j;
        r_raddr <= n_raddr;
        r_zero  <= n_zero;
        r_drew  <= n_drew;
        if (out_load) begin
            r_oshade <= r_zero ? cld_pkg::SHADE_BLACK : r_rdata;
            r_odrew  <= r_drew;
        end
    end

    // pixel memory: one write port for clearing and drawing, one registered read port
    assign we    = (r_state == S_CLEAR) || (r_state == S_DRAW);
    assign waddr = (r_state == S_CLEAR) ? r_clr : pix_addr;
    assign wdata = (r_state == S_CLEAR) ? cld_pkg::SHADE_WHITE : r_shade;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_raddr];
    end

endmodule

`default_nettype wire

FILE: src/cld_checker.sv
// port-level checker for the canvas drawer and its bind to the top level
`default_nettype none

module cld_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [cld_pkg::SHADE_W-1:0] i_start_shade
);

    // clearing pass holds off commands right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> !i_in_ready)
        else $error("command ready during clearing pass");

    // one command in flight: no back-to-back transactions
    a_one_at_a_time: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command accepted while previous still in work");

    a_shade_range: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) i_out_valid |-> (i_start_shade <= cld_pkg::SHADE_WHITE))
        else $error("result shade out of range");

    a_out_hold: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind canvas_line_square_drawer_unit cld_checker u_cld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_start_shade (o_res.start_shade)
);

`default_nettype wire
